/* rtl/bavg_pkg.sv */
// Shared constants, types and reciprocal tables for the block average downsampler.
package bavg_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_FACTOR  = 16;

   localparam int PIXEL_W     = 8;
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 16;
   localparam int FACTOR_W    = 5;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int OFS_W       = $clog2(MAX_FACTOR);
   localparam int SUM_W       = 16;
   localparam int RECIP_W     = 17;
   localparam int SHIFT_W     = 5;
   localparam int PROD_W      = SUM_W + RECIP_W;

   localparam int DIV_W       = 16;
   localparam int DIV_STEP_W  = $clog2(DIV_W);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_REDUCE_FACTOR = 2'd2;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [COL_W-1:0]   addr;
      logic               in_range;
      logic               first;
      logic               last;
      logic               row_end;
      logic               frame_end;
   } store_req_type;

   typedef struct packed {
      logic             valid;
      logic [SUM_W-1:0] sum;
      logic             row_end;
      logic             frame_end;
   } sum_out_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] mean;
      logic               row_end;
      logic               frame_end;
   } rsp_item_type;

   typedef struct packed {
      logic                done;
      logic [DIV_W-1:0]    quotient;
      logic [FACTOR_W-1:0] remainder;
   } div_result_type;

   // Multiplier m = ceil(2^s / f^2) with s = 16 + ceil(log2(f^2)); exact for 16-bit sums.
   function automatic logic [RECIP_W-1:0] recip_mult(input logic [FACTOR_W-1:0] f);
      logic [RECIP_W-1:0] m;
      case (f)
         5'd1:    m = 17'd65536;
         5'd2:    m = 17'd65536;
         5'd3:    m = 17'd116509;
         5'd4:    m = 17'd65536;
         5'd5:    m = 17'd83887;
         5'd6:    m = 17'd116509;
         5'd7:    m = 17'd85599;
         5'd8:    m = 17'd65536;
         5'd9:    m = 17'd103564;
         5'd10:   m = 17'd83887;
         5'd11:   m = 17'd69328;
         5'd12:   m = 17'd116509;
         5'd13:   m = 17'd99274;
         5'd14:   m = 17'd85599;
         5'd15:   m = 17'd74566;
         5'd16:   m = 17'd65536;
         default: m = 17'd65536;
      endcase
      return m;
   endfunction

   function automatic logic [SHIFT_W-1:0] recip_shift(input logic [FACTOR_W-1:0] f);
      logic [SHIFT_W-1:0] s;
      case (f)
         5'd1:    s = 5'd16;
         5'd2:    s = 5'd18;
         5'd3:    s = 5'd20;
         5'd4:    s = 5'd20;
         5'd5:    s = 5'd21;
         5'd6:    s = 5'd22;
         5'd7:    s = 5'd22;
         5'd8:    s = 5'd22;
         5'd9:    s = 5'd23;
         5'd10:   s = 5'd23;
         5'd11:   s = 5'd23;
         5'd12:   s = 5'd24;
         5'd13:   s = 5'd24;
         5'd14:   s = 5'd24;
         5'd15:   s = 5'd24;
         5'd16:   s = 5'd24;
         default: s = 5'd16;
      endcase
      return s;
   endfunction

endpackage

/* rtl/bavg_divider.sv */
// Bit-serial restoring divider for raster positions and image sizes by the block factor.
module bavg_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [bavg_pkg::DIV_W-1:0]     dividend,
   input  logic [bavg_pkg::FACTOR_W-1:0]  divisor,
   output bavg_pkg::div_result_type       result
);
   import bavg_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0]      work_ff, work_in;
   logic [FACTOR_W-1:0]   rem_ff, rem_in;
   logic [FACTOR_W-1:0]   divisor_ff, divisor_in;
   logic [FACTOR_W-1:0]   rem_shift;
   logic                  fits;

   always_comb begin
      rem_shift  = {rem_ff[FACTOR_W-2:0], work_ff[DIV_W-1]};
      fits       = rem_shift >= divisor_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         work_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         count_in   = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         work_in  = {work_ff[DIV_W-2:0], fits};
         rem_in   = fits ? rem_shift - divisor_ff : rem_shift;
         count_in = count_ff + DIV_STEP_W'(1);
         if (count_ff == DIV_STEP_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = work_ff;
   assign result.remainder = rem_ff;

endmodule

/* rtl/bavg_sum_store.sv */
// Accumulator line store: one block sum per block column, read-modify-write with forwarding.
module bavg_sum_store (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  bavg_pkg::store_req_type in_item,
   output bavg_pkg::sum_out_type   sum_out,
   output logic                    drop
);
   import bavg_pkg::*;

   logic [SUM_W-1:0] sums_mem [MAX_WIDTH];

   logic             b_valid_ff;
   store_req_type    b_item_ff;
   logic [SUM_W-1:0] rdata_ff;
   logic             lw_valid_ff;
   logic [COL_W-1:0] lw_addr_ff;
   logic [SUM_W-1:0] lw_data_ff;
   logic             out_valid_ff;
   logic [SUM_W-1:0] out_sum_ff;
   logic             out_row_end_ff;
   logic             out_frame_end_ff;

   logic [SUM_W-1:0] base;
   logic [SUM_W-1:0] sum;
   logic             wr_en;
   logic             emit;

   always_comb begin
      if (b_item_ff.first) begin
         base = '0;
      end else if (lw_valid_ff && lw_addr_ff == b_item_ff.addr) begin
         base = lw_data_ff;
      end else begin
         base = rdata_ff;
      end
      sum   = base + SUM_W'(b_item_ff.pixel);
      wr_en = b_valid_ff && b_item_ff.in_range;
      emit  = wr_en && b_item_ff.last;
      drop  = b_valid_ff && !emit;
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         rdata_ff <= sums_mem[in_item.addr];
      end
      if (wr_en) begin
         sums_mem[b_item_ff.addr] <= sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         lw_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= in_valid;
         lw_valid_ff  <= wr_en;
         out_valid_ff <= emit;
      end
      b_item_ff        <= in_item;
      lw_addr_ff       <= b_item_ff.addr;
      lw_data_ff       <= sum;
      out_sum_ff       <= sum;
      out_row_end_ff   <= b_item_ff.row_end;
      out_frame_end_ff <= b_item_ff.frame_end;
   end

   assign sum_out.valid     = out_valid_ff;
   assign sum_out.sum       = out_sum_ff;
   assign sum_out.row_end   = out_row_end_ff;
   assign sum_out.frame_end = out_frame_end_ff;

endmodule

/* rtl/bavg_mean.sv */
// Block mean by reciprocal multiplication and shift.
module bavg_mean (
   input  logic                          clock,
   input  logic                          reset,
   input  bavg_pkg::sum_out_type         sum_in,
   input  logic [bavg_pkg::FACTOR_W-1:0] factor,
   output logic                          mean_valid,
   output bavg_pkg::rsp_item_type        mean_item
);
   import bavg_pkg::*;

   logic               valid_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [SHIFT_W-1:0] shift_ff;
   logic               row_end_ff;
   logic               frame_end_ff;
   logic [PROD_W-1:0]  shifted;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= sum_in.valid;
      end
      prod_ff      <= PROD_W'(sum_in.sum) * PROD_W'(recip_mult(factor));
      shift_ff     <= recip_shift(factor);
      row_end_ff   <= sum_in.row_end;
      frame_end_ff <= sum_in.frame_end;
   end

   assign shifted             = prod_ff >> shift_ff;
   assign mean_valid          = valid_ff;
   assign mean_item.mean      = shifted[PIXEL_W-1:0];
   assign mean_item.row_end   = row_end_ff;
   assign mean_item.frame_end = frame_end_ff;

endmodule

/* rtl/block_average_downsample.sv */
// Top level of the block average downsampler.
//
// Takes one 8-bit pixel per cycle in raster order while not stalled and returns the truncated
// mean of each full factor-by-factor block, marked at the end of each output row and of the
// frame. Pixels of trailing rows and columns that do not fill a block are taken and produce
// nothing. The sustained rate is one pixel per cycle when not stalled: each pixel costs one
// read-modify-write of the accumulator line store, with the last written sum forwarded to the
// next read of the same address. A result passes the line store's pipeline and the mean's
// product register and waits in an eight-item output queue. After reset and after every
// register write the input stalls while a bit-serial divider recomputes the block column,
// block row, offsets and block counts (four 16-bit divisions by the factor). The line store
// needs no clearing: each block's first pixel overwrites its accumulator.
module block_average_downsample (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [bavg_pkg::PIXEL_W-1:0]     req_pixel_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [bavg_pkg::PIXEL_W-1:0]     rsp_block_mean,
   output logic                             rsp_row_end,
   output logic                             rsp_frame_end,
   input  logic                             csr_write_enable,
   input  logic [bavg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bavg_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import bavg_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_COL  = 3'd1;
   localparam logic [2:0] ST_ROW  = 3'd2;
   localparam logic [2:0] ST_WID  = 3'd3;
   localparam logic [2:0] ST_HGT  = 3'd4;

   logic [WIDTH_W-1:0]    image_width_ff;
   logic [HEIGHT_W-1:0]   image_height_ff;
   logic [FACTOR_W-1:0]   reduce_factor_ff;
   logic [WIDTH_W-1:0]    w_eff;
   logic [HEIGHT_W-1:0]   h_eff;
   logic [FACTOR_W-1:0]   f_eff;

   logic [2:0]            state_ff, state_in;
   logic                  pending_ff, pending_in;
   logic                  pending_clear;

   logic [COL_W-1:0]      col_ff, col_in, col_wrap;
   logic [HEIGHT_W-1:0]   row_ff, row_in, row_wrap;
   logic [OFS_W-1:0]      cib_ff, cib_in;
   logic [OFS_W-1:0]      rib_ff, rib_in;
   logic [COL_W-1:0]      bc_ff, bc_in;
   logic [HEIGHT_W-1:0]   br_ff, br_in;
   logic [WIDTH_W-1:0]    full_cols_ff, full_cols_in;
   logic [HEIGHT_W-1:0]   full_rows_ff, full_rows_in;

   logic                  div_start;
   logic [DIV_W-1:0]      div_dividend;
   div_result_type        div_result;

   logic                  req_accept;
   logic                  rsp_accept;
   store_req_type         store_req;
   sum_out_type           sum_out;
   logic                  item_drop;
   logic                  mean_valid;
   rsp_item_type          mean_item;

   logic [FIFO_PTR_W:0]   reserved_ff, reserved_in;
   rsp_item_type          fifo_mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_PTR_W:0]   count_ff, count_in;
   rsp_item_type          head_item;

   logic                  col_last, row_last, cib_last, rib_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= WIDTH_W'(MAX_WIDTH);
         image_height_ff  <= HEIGHT_W'(1);
         reduce_factor_ff <= FACTOR_W'(2);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:   image_width_ff   <= csr_write_data[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT:  image_height_ff  <= csr_write_data[HEIGHT_W-1:0];
            REG_REDUCE_FACTOR: reduce_factor_ff <= csr_write_data[FACTOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (image_width_ff == '0) begin
         w_eff = WIDTH_W'(1);
      end else if (image_width_ff > WIDTH_W'(MAX_WIDTH)) begin
         w_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_eff = image_width_ff;
      end
      h_eff = (image_height_ff == '0) ? HEIGHT_W'(1) : image_height_ff;
      if (reduce_factor_ff == '0) begin
         f_eff = FACTOR_W'(1);
      end else if (reduce_factor_ff > FACTOR_W'(MAX_FACTOR)) begin
         f_eff = FACTOR_W'(MAX_FACTOR);
      end else begin
         f_eff = reduce_factor_ff;
      end
   end

   assign req_stall  = pending_ff || (state_ff != ST_IDLE) ||
                       (reserved_ff == (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   always_comb begin
      col_wrap = (WIDTH_W'(col_ff) >= w_eff) ? '0 : col_ff;
      row_wrap = (row_ff >= h_eff) ? '0 : row_ff;
      col_last = (WIDTH_W'(col_ff) + WIDTH_W'(1)) >= w_eff;
      row_last = (row_ff + HEIGHT_W'(1)) >= h_eff;
      cib_last = (FACTOR_W'(cib_ff) + FACTOR_W'(1)) == f_eff;
      rib_last = (FACTOR_W'(rib_ff) + FACTOR_W'(1)) == f_eff;

      store_req.pixel     = req_pixel_value;
      store_req.addr      = bc_ff;
      store_req.in_range  = (WIDTH_W'(bc_ff) < full_cols_ff) && (br_ff < full_rows_ff);
      store_req.first     = (cib_ff == '0) && (rib_ff == '0);
      store_req.last      = cib_last && rib_last;
      store_req.row_end   = WIDTH_W'(bc_ff) == (full_cols_ff - WIDTH_W'(1));
      store_req.frame_end = store_req.row_end && (br_ff == (full_rows_ff - HEIGHT_W'(1)));
   end

   always_comb begin
      state_in      = state_ff;
      pending_clear = 1'b0;
      div_start     = 1'b0;
      div_dividend  = '0;
      col_in        = col_ff;
      row_in        = row_ff;
      cib_in        = cib_ff;
      rib_in        = rib_ff;
      bc_in         = bc_ff;
      br_in         = br_ff;
      full_cols_in  = full_cols_ff;
      full_rows_in  = full_rows_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pending_ff) begin
               pending_clear = 1'b1;
               col_in        = col_wrap;
               row_in        = row_wrap;
               div_start     = 1'b1;
               div_dividend  = DIV_W'(col_wrap);
               state_in      = ST_COL;
            end else if (req_accept) begin
               if (col_last) begin
                  col_in = '0;
                  cib_in = '0;
                  bc_in  = '0;
                  if (row_last) begin
                     row_in = '0;
                     rib_in = '0;
                     br_in  = '0;
                  end else begin
                     row_in = row_ff + HEIGHT_W'(1);
                     if (rib_last) begin
                        rib_in = '0;
                        br_in  = br_ff + HEIGHT_W'(1);
                     end else begin
                        rib_in = rib_ff + OFS_W'(1);
                     end
                  end
               end else begin
                  col_in = col_ff + COL_W'(1);
                  if (cib_last) begin
                     cib_in = '0;
                     bc_in  = bc_ff + COL_W'(1);
                  end else begin
                     cib_in = cib_ff + OFS_W'(1);
                  end
               end
            end
         end
         ST_COL: begin
            if (div_result.done) begin
               bc_in        = div_result.quotient[COL_W-1:0];
               cib_in       = div_result.remainder[OFS_W-1:0];
               div_start    = 1'b1;
               div_dividend = DIV_W'(row_ff);
               state_in     = ST_ROW;
            end
         end
         ST_ROW: begin
            if (div_result.done) begin
               br_in        = div_result.quotient[HEIGHT_W-1:0];
               rib_in       = div_result.remainder[OFS_W-1:0];
               div_start    = 1'b1;
               div_dividend = DIV_W'(w_eff);
               state_in     = ST_WID;
            end
         end
         ST_WID: begin
            if (div_result.done) begin
               full_cols_in = div_result.quotient[WIDTH_W-1:0];
               div_start    = 1'b1;
               div_dividend = DIV_W'(h_eff);
               state_in     = ST_HGT;
            end
         end
         ST_HGT: begin
            if (div_result.done) begin
               full_rows_in = div_result.quotient[HEIGHT_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      pending_in = csr_write_enable || (pending_ff && !pending_clear);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= 1'b1;
         col_ff       <= '0;
         row_ff       <= '0;
         cib_ff       <= '0;
         rib_ff       <= '0;
         bc_ff        <= '0;
         br_ff        <= '0;
         full_cols_ff <= '0;
         full_rows_ff <= '0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         cib_ff       <= cib_in;
         rib_ff       <= rib_in;
         bc_ff        <= bc_in;
         br_ff        <= br_in;
         full_cols_ff <= full_cols_in;
         full_rows_ff <= full_rows_in;
      end
   end

   bavg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (f_eff),
      .result   (div_result)
   );

   bavg_sum_store u_sum_store (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_accept),
      .in_item  (store_req),
      .sum_out  (sum_out),
      .drop     (item_drop)
   );

   bavg_mean u_mean (
      .clock      (clock),
      .reset      (reset),
      .sum_in     (sum_out),
      .factor     (f_eff),
      .mean_valid (mean_valid),
      .mean_item  (mean_item)
   );

   // Every accepted item holds a queue slot until it is dropped or its result is taken.
   assign reserved_in = reserved_ff + (FIFO_PTR_W+1)'(req_accept)
                        - (FIFO_PTR_W+1)'(item_drop) - (FIFO_PTR_W+1)'(rsp_accept);
   assign count_in    = count_ff + (FIFO_PTR_W+1)'(mean_valid) - (FIFO_PTR_W+1)'(rsp_accept);

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= '0;
         count_ff    <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
      end else begin
         reserved_ff <= reserved_in;
         count_ff    <= count_in;
         if (mean_valid) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (rsp_accept) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mean_valid) begin
         fifo_mem[wr_ptr_ff] <= mean_item;
      end
   end

   assign head_item      = fifo_mem[rd_ptr_ff];
   assign rsp_valid      = count_ff != '0;
   assign rsp_block_mean = head_item.mean;
   assign rsp_row_end    = head_item.row_end;
   assign rsp_frame_end  = head_item.frame_end;

endmodule

/* rtl/bavg_checker.sv */
// Port-level assertions for the block average downsampler and their binding.
module bavg_port_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_block_mean,
   input logic       rsp_row_end,
   input logic       rsp_frame_end,
   input logic       csr_write_enable
);

   // A register write stalls input until block positions are recomputed.
   assert property (@(posedge clock) disable iff (reset) csr_write_enable |=> req_stall)
      else $error("input not stalled after a register write");

   // A result can first show only after the item that completed its block has passed the pipeline.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 4))
      else $error("result appeared without a matching item");

   // The last block of a frame also closes its output row.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame end without row end");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_block_mean))
      else $error("stalled result changed");

endmodule

bind block_average_downsample bavg_port_checker u_checker (.*);
